FILE: design/vrw_pkg.sv
// ----------------------------------------------------------------------------
// vrw_pkg
// Shared constants, types and the overlay color lookup for the video RAM
// write block.
// ----------------------------------------------------------------------------
package vrw_pkg;

  // video store geometry
  localparam int VIDEO_BYTES = 7168;
  localparam int ADDR_W      = $clog2(VIDEO_BYTES);
  localparam int OFF_W       = 13;
  localparam int DATA_W      = 8;
  localparam int X_W         = 8;
  localparam int Y_W         = 10;
  localparam int PIX_Y_W     = 9;
  localparam int COLOR_W     = 3;
  localparam int SH_RESET    = 256;

  // stream word widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 64;

  // overlay color codes
  localparam logic [COLOR_W-1:0] COLOR_WHITE  = 3'd0;
  localparam logic [COLOR_W-1:0] COLOR_CYAN   = 3'd1;
  localparam logic [COLOR_W-1:0] COLOR_RED    = 3'd2;
  localparam logic [COLOR_W-1:0] COLOR_YELLOW = 3'd3;
  localparam logic [COLOR_W-1:0] COLOR_GREEN  = 3'd4;
  localparam logic [COLOR_W-1:0] COLOR_PURPLE = 3'd5;
  localparam logic [COLOR_W-1:0] COLOR_BLACK  = 3'd6;

  localparam logic [X_W-1:0] BLACK_COLUMN = 8'd223;

  // controller -> datapath
  typedef struct packed {
    logic clear_wr;  // write zero at the clear pointer, advance it
    logic load;      // capture input word, start store read
    logic update;    // commit write, widen dirty box, load pixel regs
    logic shift;     // advance to the next pixel
  } vrw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;  // clear pointer at the final entry
    logic in_range;    // offset on the input bus hits the store
    logic differs;     // new byte differs from the stored one
  } vrw_sts_t;

  function automatic logic [COLOR_W-1:0] pick_color(input logic [X_W-1:0] x,
                                                    input logic [Y_W-1:0] y);
    logic [COLOR_W-1:0] c;
    c = COLOR_WHITE;
    if (y < 10'd16) begin
      c = COLOR_WHITE;
    end else if (y < 10'd24) begin
      c = (x < 8'd72) ? COLOR_CYAN : (x < 8'd152) ? COLOR_RED : COLOR_YELLOW;
    end else if (y < 10'd32) begin
      c = (x < 8'd72) ? COLOR_CYAN : (x < 8'd160) ? COLOR_GREEN : COLOR_YELLOW;
    end else if (y < 10'd40) begin
      c = (x < 8'd72) ? COLOR_WHITE : (x < 8'd160) ? COLOR_GREEN : COLOR_YELLOW;
    end else if (y < 10'd48) begin
      c = COLOR_RED;
    end else if (y < 10'd72) begin
      c = COLOR_PURPLE;
    end else if (y < 10'd104) begin
      c = COLOR_GREEN;
    end else if (y < 10'd136) begin
      c = COLOR_CYAN;
    end else if (y < 10'd168) begin
      c = COLOR_PURPLE;
    end else if (y < 10'd200) begin
      c = COLOR_YELLOW;
    end else if (y < 10'd224) begin
      c = COLOR_RED;
    end else if (y < 10'd240) begin
      c = COLOR_CYAN;
    end else if (y < 10'd248) begin
      c = COLOR_RED;
    end else begin
      c = (x < 8'd136) ? COLOR_CYAN : (x < 8'd192) ? COLOR_PURPLE : COLOR_CYAN;
    end
    if (x == BLACK_COLUMN) begin
      c = COLOR_BLACK;
    end
    return c;
  endfunction

endpackage

FILE: design/vrw_ctrl.sv
// ----------------------------------------------------------------------------
// vrw_ctrl
// Sequencer: store clear after reset, accept, compare, eight pixel words.
// ----------------------------------------------------------------------------
module vrw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_last,
  input  vrw_pkg::vrw_sts_t sts,
  output vrw_pkg::vrw_cmd_t cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [2:0] bit_cnt;
  logic [2:0] bit_cnt_next;

  always_comb begin
    state_next   = state;
    bit_cnt_next = bit_cnt;
    cmd          = '0;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.in_range) begin
            state_next = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        if (sts.differs) begin
          cmd.update   = 1'b1;
          bit_cnt_next = 3'd0;
          state_next   = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.shift    = 1'b1;
          bit_cnt_next = bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_last = (bit_cnt == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      bit_cnt <= 3'd0;
    end else begin
      state   <= state_next;
      bit_cnt <= bit_cnt_next;
    end
  end

endmodule

FILE: design/vrw_dp.sv
// ----------------------------------------------------------------------------
// vrw_dp
// Datapath: video store, dirty box, color pick and pixel output registers.
// ----------------------------------------------------------------------------
module vrw_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  vrw_pkg::vrw_cmd_t             cmd,
  output vrw_pkg::vrw_sts_t             sts,
  input  logic [vrw_pkg::Y_W-1:0]       screen_height,
  input  logic [vrw_pkg::OFF_W-1:0]     in_offset,
  input  logic [vrw_pkg::DATA_W-1:0]    in_data,
  output logic [vrw_pkg::X_W-1:0]       pixel_x,
  output logic [vrw_pkg::PIX_Y_W-1:0]   pixel_y,
  output logic [vrw_pkg::COLOR_W-1:0]   color_index,
  output logic                          pixel_lit,
  output logic [vrw_pkg::X_W-1:0]       dirty_min_x,
  output logic [vrw_pkg::X_W-1:0]       dirty_max_x,
  output logic [vrw_pkg::Y_W-1:0]       dirty_min_y,
  output logic [vrw_pkg::Y_W-1:0]       dirty_max_y
);

  logic [vrw_pkg::DATA_W-1:0] store [vrw_pkg::VIDEO_BYTES];

  logic [vrw_pkg::ADDR_W-1:0] clear_addr;
  logic [vrw_pkg::OFF_W-1:0]  off_reg;
  logic [vrw_pkg::DATA_W-1:0] data_reg;
  logic [vrw_pkg::DATA_W-1:0] rd_data;
  logic [vrw_pkg::DATA_W-1:0] pix_bits;

  logic [vrw_pkg::Y_W-1:0] dirty_left;
  logic [vrw_pkg::Y_W-1:0] dirty_right;
  logic [vrw_pkg::Y_W-1:0] dirty_top;
  logic [vrw_pkg::Y_W-1:0] dirty_bottom;

  logic [vrw_pkg::X_W-1:0] x_new;
  logic [vrw_pkg::Y_W-1:0] x_plus1;
  logic [vrw_pkg::Y_W-1:0] y_new;
  logic [vrw_pkg::Y_W-1:0] ytop_new;

  // column and base row of the held write
  assign x_new    = off_reg[vrw_pkg::OFF_W-1:5];
  assign x_plus1  = vrw_pkg::Y_W'(x_new) + 10'd1;
  assign y_new    = screen_height - {2'b00, off_reg[4:0], 3'b000};
  assign ytop_new = y_new - 10'd8;

  assign sts.clear_last = (clear_addr == vrw_pkg::ADDR_W'(vrw_pkg::VIDEO_BYTES - 1));
  assign sts.in_range   = ({1'b0, in_offset} < 14'(vrw_pkg::VIDEO_BYTES));
  assign sts.differs    = (rd_data != data_reg);

  // store: one write port (clear or commit), one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      store[clear_addr] <= '0;
    end else if (cmd.update) begin
      store[off_reg[vrw_pkg::ADDR_W-1:0]] <= data_reg;
    end
    if (cmd.load) begin
      rd_data <= store[in_offset[vrw_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_wr) begin
      clear_addr <= clear_addr + vrw_pkg::ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      off_reg  <= in_offset;
      data_reg <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dirty_left   <= 10'd224;
      dirty_right  <= 10'd0;
      dirty_top    <= 10'd512;
      dirty_bottom <= 10'd0;
    end else if (cmd.update) begin
      if (vrw_pkg::Y_W'(x_new) < dirty_left) begin
        dirty_left <= vrw_pkg::Y_W'(x_new);
      end
      if (x_plus1 > dirty_right) begin
        dirty_right <= x_plus1;
      end
      if (ytop_new < dirty_top) begin
        dirty_top <= ytop_new;
      end
      if (y_new > dirty_bottom) begin
        dirty_bottom <= y_new;
      end
    end
  end

  // pixel registers: row counts down, data shifts out LSB first
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      pixel_x     <= x_new;
      color_index <= vrw_pkg::pick_color(x_new, y_new);
      pixel_y     <= y_new[vrw_pkg::PIX_Y_W-1:0] - 9'd1;
      pix_bits    <= data_reg;
    end else if (cmd.shift) begin
      pixel_y  <= pixel_y - 9'd1;
      pix_bits <= {1'b0, pix_bits[vrw_pkg::DATA_W-1:1]};
    end
  end

  assign pixel_lit   = pix_bits[0];
  assign dirty_min_x = dirty_left[vrw_pkg::X_W-1:0];
  assign dirty_max_x = dirty_right[vrw_pkg::X_W-1:0];
  assign dirty_min_y = dirty_top;
  assign dirty_max_y = dirty_bottom;

endmodule

FILE: design/video_ram_write_color_overlay.sv
// ----------------------------------------------------------------------------
// video_ram_write_color_overlay
// Byte write port of a 1-bit-per-pixel rotated video RAM with color overlay.
// ----------------------------------------------------------------------------
// Each input word is a CPU byte write (offset, data). After reset the block
// clears its 7168-byte store, one byte per cycle, and holds s_tready low
// until the clear is done; APB writes are taken meanwhile. A write whose
// offset is past the store is dropped in its accept cycle. Otherwise the
// stored byte is read (one registered read port) and compared in the next
// cycle: an unchanged byte ends there. A changed byte is stored, the dirty
// box widened and eight pixel words follow, one per cycle while m_tready is
// high, LSB first, the last one marked by m_tlast. The next write is
// accepted in the cycle after the eighth pixel word leaves.
// ----------------------------------------------------------------------------
module video_ram_write_color_overlay (
  input  logic        clk,
  input  logic        rst,
  // write stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // byte_offset[12:0], write_data[20:13], zero
  // pixel stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // pixel_x[7:0], pixel_y[16:8],
                                 // color_index[19:17], pixel_lit[20],
                                 // dirty_min_x[28:21], dirty_max_x[36:29],
                                 // dirty_min_y[46:37], dirty_max_y[56:47], zero
  output logic        m_tlast,   // last_pixel
  // APB config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  vrw_pkg::vrw_cmd_t cmd;
  vrw_pkg::vrw_sts_t sts;

  logic [vrw_pkg::Y_W-1:0]     screen_height;
  logic [vrw_pkg::X_W-1:0]     pixel_x;
  logic [vrw_pkg::PIX_Y_W-1:0] pixel_y;
  logic [vrw_pkg::COLOR_W-1:0] color_index;
  logic                        pixel_lit;
  logic [vrw_pkg::X_W-1:0]     dirty_min_x;
  logic [vrw_pkg::X_W-1:0]     dirty_max_x;
  logic [vrw_pkg::Y_W-1:0]     dirty_min_y;
  logic [vrw_pkg::Y_W-1:0]     dirty_max_y;
  logic                        cfg_wr;

  // register 0 at byte 0; anything with paddr[2] set is past the map
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & ~paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_height <= vrw_pkg::Y_W'(vrw_pkg::SH_RESET);
    end else if (cfg_wr) begin
      screen_height <= pwdata[vrw_pkg::Y_W-1:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {22'd0, screen_height};

  vrw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_last  (m_tlast),
    .sts       (sts),
    .cmd       (cmd)
  );

  vrw_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .screen_height (screen_height),
    .in_offset     (s_tdata[12:0]),
    .in_data       (s_tdata[20:13]),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .color_index   (color_index),
    .pixel_lit     (pixel_lit),
    .dirty_min_x   (dirty_min_x),
    .dirty_max_x   (dirty_max_x),
    .dirty_min_y   (dirty_min_y),
    .dirty_max_y   (dirty_max_y)
  );

  // pack the pixel word, first field lowest
  assign m_tdata = {7'd0, dirty_max_y, dirty_min_y, dirty_max_x, dirty_min_x,
                    pixel_lit, color_index, pixel_y, pixel_x};

endmodule

FILE: tb/sv/video_ram_write_color_overlay_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// video_ram_write_color_overlay_test
// Self-checking bench for the video RAM byte write port with color overlay.
// Byte writes go in on the slave stream and pixel words are checked against
// a cycle-free model of the store, the dirty box and the overlay bands.
// The screen height register is swept over its extremes between phases.
// ----------------------------------------------------------------------------

typedef struct {
  logic [7:0] x;
  logic [8:0] y;
  logic [2:0] color;
  logic       lit;
  logic       last;
  logic [7:0] min_x;
  logic [7:0] max_x;
  logic [9:0] min_y;
  logic [9:0] max_y;
} pixel_t;

// Tracks the video store and dirty box, queues the pixel words each
// accepted write should produce and compares them as they leave.
class pixel_tracker;
  localparam int MAX_REPORTS = 10;

  logic [7:0] vram [vrw_pkg::VIDEO_BYTES];
  logic [9:0] height;
  logic [9:0] left, right, top, bottom;
  pixel_t     pending_pixels [$];
  int         errors;

  function new();
    foreach (vram[i]) vram[i] = 8'h00;
    height = 10'd256;
    left   = 10'd224;
    right  = 10'd0;
    top    = 10'd512;
    bottom = 10'd0;
    errors = 0;
  endfunction

  function void set_height(logic [9:0] h);
    height = h;
  endfunction

  function logic [7:0] stored(logic [12:0] off);
    return vram[off];
  endfunction

  function int leftover();
    return pending_pixels.size();
  endfunction

  // overlay bands keyed on the base row, black column wins over all
  function logic [2:0] overlay_color(logic [7:0] x, logic [9:0] y);
    logic [2:0] c;
    if (y >= 10'd248)
      c = (x >= 8'd136 && x < 8'd192) ? vrw_pkg::COLOR_PURPLE : vrw_pkg::COLOR_CYAN;
    else if (y >= 10'd240) c = vrw_pkg::COLOR_RED;
    else if (y >= 10'd224) c = vrw_pkg::COLOR_CYAN;
    else if (y >= 10'd200) c = vrw_pkg::COLOR_RED;
    else if (y >= 10'd168) c = vrw_pkg::COLOR_YELLOW;
    else if (y >= 10'd136) c = vrw_pkg::COLOR_PURPLE;
    else if (y >= 10'd104) c = vrw_pkg::COLOR_CYAN;
    else if (y >= 10'd72)  c = vrw_pkg::COLOR_GREEN;
    else if (y >= 10'd48)  c = vrw_pkg::COLOR_PURPLE;
    else if (y >= 10'd40)  c = vrw_pkg::COLOR_RED;
    else if (y >= 10'd32)
      c = (x < 8'd72) ? vrw_pkg::COLOR_WHITE :
          (x < 8'd160) ? vrw_pkg::COLOR_GREEN : vrw_pkg::COLOR_YELLOW;
    else if (y >= 10'd24)
      c = (x < 8'd72) ? vrw_pkg::COLOR_CYAN :
          (x < 8'd160) ? vrw_pkg::COLOR_GREEN : vrw_pkg::COLOR_YELLOW;
    else if (y >= 10'd16)
      c = (x < 8'd72) ? vrw_pkg::COLOR_CYAN :
          (x < 8'd152) ? vrw_pkg::COLOR_RED : vrw_pkg::COLOR_YELLOW;
    else
      c = vrw_pkg::COLOR_WHITE;
    if (x == 8'd223) c = vrw_pkg::COLOR_BLACK;
    return c;
  endfunction

  // returns the number of pixel words the write produces (0 or 8)
  function int take_write(logic [12:0] off, logic [7:0] data);
    logic [9:0] x, y, ytop, row;
    logic [2:0] c;
    pixel_t     p;
    if (off >= vrw_pkg::VIDEO_BYTES) return 0;
    if (vram[off] == data) return 0;
    vram[off] = data;
    x    = {2'b0, off[12:5]};
    y    = height - {2'b00, off[4:0], 3'b000};
    ytop = y - 10'd8;
    if (x < left) left = x;
    if (x + 10'd1 > right) right = x + 10'd1;
    if (ytop < top) top = ytop;
    if (y > bottom) bottom = y;
    c = overlay_color(x[7:0], y);
    for (int b = 0; b < 8; b++) begin
      row     = y - 10'(b) - 10'd1;
      p.x     = x[7:0];
      p.y     = row[8:0];
      p.color = c;
      p.lit   = data[b];
      p.last  = (b == 7);
      p.min_x = left[7:0];
      p.max_x = right[7:0];
      p.min_y = top;
      p.max_y = bottom;
      pending_pixels.push_back(p);
    end
    return 8;
  endfunction

  function string show(pixel_t p);
    return $sformatf("x=%0d y=%0d c=%0d lit=%0d last=%0d box=(%0d..%0d, %0d..%0d)",
                     p.x, p.y, p.color, p.lit, p.last, p.min_x, p.max_x, p.min_y, p.max_y);
  endfunction

  function void check_pixel(pixel_t got);
    pixel_t want;
    bit     bad;
    if (pending_pixels.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS) $display("unexpected pixel word: %s", show(got));
      return;
    end
    want = pending_pixels.pop_front();
    bad  = 0;
    if (got.x     !== want.x)     bad = 1;
    if (got.y     !== want.y)     bad = 1;
    if (got.color !== want.color) bad = 1;
    if (got.lit   !== want.lit)   bad = 1;
    if (got.last  !== want.last)  bad = 1;
    if (got.min_x !== want.min_x) bad = 1;
    if (got.max_x !== want.max_x) bad = 1;
    if (got.min_y !== want.min_y) bad = 1;
    if (got.max_y !== want.max_y) bad = 1;
    if (bad) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("pixel mismatch\n  expected %s\n  actual   %s", show(want), show(got));
      end
    end
  endfunction
endclass

module video_ram_write_color_overlay_test;

  localparam int          HALF_PERIOD   = 6;
  localparam int unsigned CYCLE_LIMIT   = 600000;  // clear pass + slowest run, several times
  localparam int          HOLD_CYCLES   = 400;     // long receiver hold-off
  localparam int          SETTLE_CYCLES = 12;      // covers an unchanged-byte compare in flight
  localparam int          PHASE_WRITES  = 32;      // changed bytes per random phase

  // register map
  localparam logic [2:0] HEIGHT_ADDR = 3'd0;
  localparam logic [2:0] SPARE_ADDR  = 3'd4;  // no register behind it

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // byte_offset[12:0], write_data[20:13], zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // pixel_x, pixel_y, color_index, pixel_lit, dirty box
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pixel_tracker tracker = new();

  int unsigned cycle_count = 0;
  bit          gaps_on = 1'b1;   // sender may idle between words
  bit          calm = 1'b0;      // end of run: no idling on either side
  bit          hold_req = 1'b0;  // asks the receiver for one long hold-off

  video_ram_write_color_overlay dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("video_ram_write_color_overlay_test: errors");
    $finish;
  end

  // pixel word monitor, sampled at the rising edge
  always @(posedge clk) begin
    pixel_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.x     = m_tdata[7:0];
      got.y     = m_tdata[16:8];
      got.color = m_tdata[19:17];
      got.lit   = m_tdata[20];
      got.last  = m_tlast;
      got.min_x = m_tdata[28:21];
      got.max_x = m_tdata[36:29];
      got.min_y = m_tdata[46:37];
      got.max_y = m_tdata[56:47];
      tracker.check_pixel(got);
    end
  end

  // Receiver: ready runs and stall bursts; one long hold-off on request so
  // the block backs up and stalls its input.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (calm || $urandom_range(0, 2) != 0) begin
        n = calm ? 1 : $urandom_range(1, 40);
        m_tready <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end else begin
        n = $urandom_range(1, 14);
        m_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  task automatic idle_sender(input int n);
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // one byte write; valid stays up into the next word unless a gap follows
  task automatic send_write(input logic [12:0] off, input logic [7:0] data, output int made);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, data, off};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    made = tracker.take_write(off, data);
    if (gaps_on && !calm && $urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 14));
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == HEIGHT_ADDR) tracker.set_height(value[9:0]);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stop sending and wait until every pixel word is out and the block is idle
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (tracker.leftover() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random write: mostly changed bytes anywhere in the store, some rewrites
  // of the stored byte and some offsets past the store.
  task automatic random_write(output int made);
    int         r;
    logic [12:0] off;
    logic [7:0]  data;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      off  = 13'($urandom_range(vrw_pkg::VIDEO_BYTES, 8191));
      data = 8'($urandom_range(0, 255));
    end else if (r < 16) begin
      off  = 13'($urandom_range(0, vrw_pkg::VIDEO_BYTES - 1));
      data = tracker.stored(off);
    end else begin
      off  = 13'($urandom_range(0, vrw_pkg::VIDEO_BYTES - 1));
      data = 8'($urandom_range(0, 255));
    end
    send_write(off, data, made);
  endtask

  // runs until the given number of writes have produced pixel words
  task automatic run_phase(input int target);
    int made;
    int done_writes;
    done_writes = 0;
    while (done_writes < target) begin
      random_write(made);
      if (made != 0) done_writes++;
    end
  endtask

  // Directed words at the reset height of 256: base row = 256 - 8*(offset%32),
  // so row slot 0 -> 256, 1 -> 248, 28 -> 32, 29 -> 24, 30 -> 16, 31 -> 8.
  task automatic directed_writes();
    int made;
    send_write(13'd0,    8'hFF, made);  // first byte, top band
    send_write(13'd0,    8'hFF, made);  // unchanged byte, no pixels
    send_write(13'd0,    8'h00, made);  // all pixels cleared
    send_write(13'd2301, 8'h01, made);  // x 71, row 24: cyan side
    send_write(13'd2333, 8'h80, made);  // x 72, row 24: green
    send_write(13'd5117, 8'h3C, made);  // x 159, row 24: green
    send_write(13'd5149, 8'hC3, made);  // x 160, row 24: yellow
    send_write(13'd30,   8'hAA, made);  // x 0, row 16: cyan
    send_write(13'd4862, 8'h55, made);  // x 151, row 16: red
    send_write(13'd4894, 8'hF0, made);  // x 152, row 16: yellow
    send_write(13'd348,  8'h0F, made);  // x 10, row 32: white
    send_write(13'd3228, 8'h11, made);  // x 100, row 32: green
    send_write(13'd6428, 8'h22, made);  // x 200, row 32: yellow
    send_write(13'd4321, 8'h44, made);  // x 135, row 248: cyan
    send_write(13'd4353, 8'h88, made);  // x 136, row 248: purple
    send_write(13'd6113, 8'h7E, made);  // x 191, row 248: purple
    send_write(13'd6145, 8'hE7, made);  // x 192, row 248: cyan again
    send_write(13'd7167, 8'h55, made);  // last byte, black column
    send_write(13'd7136, 8'h0F, made);  // black column, base row 256
    send_write(13'd7168, 8'hAA, made);  // just past the store, dropped
    send_write(13'd8191, 8'hFF, made);  // largest offset, dropped
    send_write(13'd166,  8'hFE, made);  // row 208: red band
  endtask

  // main sequence
  initial begin
    logic [9:0] heights [8];
    heights[0] = 10'd8;     // smallest screen, rows wrap into the top band
    heights[1] = 10'd512;   // largest screen
    heights[2] = 10'($urandom_range(8, 512));
    heights[3] = 10'd256;
    heights[4] = 10'($urandom_range(8, 512));
    heights[5] = 10'd9;
    heights[6] = 10'd511;
    heights[7] = 10'($urandom_range(8, 512));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_writes();
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 2) apb_write(SPARE_ADDR, 32'h0000_0123);  // must be ignored
      apb_write(HEIGHT_ADDR, {22'b0, heights[ph]});
      gaps_on = (ph % 3) != 1;
      if (ph == 3) begin
        // receiver holds off while the sender keeps offering words
        hold_req = 1'b1;
        gaps_on  = 1'b0;
        run_phase(16);
        gaps_on  = 1'b1;
        run_phase(PHASE_WRITES - 16);
      end else begin
        if (ph == 7) calm = 1'b1;
        run_phase(PHASE_WRITES);
      end
      // sender waits for every pixel word before the next register write
      settle();
    end

    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.leftover() == 0) begin
      $display("video_ram_write_color_overlay_test: clean");
    end else begin
      $display("video_ram_write_color_overlay_test: errors");
    end
    $finish;
  end

endmodule
